/* rtl/bfa_pkg.sv */
// ---------------------------------------------------------------------------
// bfa_pkg
// Shared types and constants of the first-fit paragraph allocator.
// ---------------------------------------------------------------------------
package bfa_pkg;

    localparam int NUM_PARAGRAPHS = 2048;
    localparam int PARA_W         = $clog2(NUM_PARAGRAPHS);
    localparam int WORD_W         = 32;
    localparam int BIT_W          = $clog2(WORD_W);
    localparam int NUM_WORDS      = NUM_PARAGRAPHS / WORD_W;
    localparam int WADDR_W        = $clog2(NUM_WORDS);
    localparam int CHUNK_W        = 8;
    localparam int CSEL_W         = $clog2(WORD_W / CHUNK_W);
    localparam int CBIT_W         = $clog2(CHUNK_W);
    localparam int TABLE_ENTRIES  = 512;
    localparam int SLOT_W         = $clog2(TABLE_ENTRIES);
    localparam int COUNT_W        = 12;
    localparam int ADDR_W         = 20;
    localparam int SHIFT_W        = 9;   // log2 of 512-byte paragraphs
    localparam int STATUS_W       = 3;

    // Paragraphs 4 to 7 are reserved after reset.
    localparam logic [WORD_W-1:0] RESERVED_WORD = WORD_W'(8'hF0);

    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NO_RUN    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
    localparam logic [STATUS_W-1:0] ST_ZERO      = 3'd4;

    // One block table entry; a zero length marks an empty slot.
    typedef struct packed {
        logic [PARA_W-1:0]  start;
        logic [COUNT_W-1:0] len;
    } t_entry;

    // Running state of the free-run search.
    typedef struct packed {
        logic               found;
        logic [COUNT_W-1:0] run;
        logic [PARA_W-1:0]  start;
    } t_scan;

    // Byte address of a paragraph, kept to the address width.
    function automatic logic [ADDR_W-1:0] para_addr(input logic [PARA_W-1:0] p);
        return ADDR_W'({p, SHIFT_W'(0)});
    endfunction

endpackage

/* rtl/bfa_bitmap.sv */
// ---------------------------------------------------------------------------
// bfa_bitmap
// Occupancy bitmap memory, one word of paragraphs per address, registered read.
// ---------------------------------------------------------------------------
module bfa_bitmap (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [bfa_pkg::WADDR_W-1:0]   i_waddr,
    input  logic [bfa_pkg::WORD_W-1:0]    i_wdata,
    input  logic [bfa_pkg::WADDR_W-1:0]   i_raddr,
    output logic [bfa_pkg::WORD_W-1:0]    o_rdata
);
    import bfa_pkg::*;

    logic [WORD_W-1:0] r_mem [NUM_WORDS];
    logic [WORD_W-1:0] r_rdata;

    // Single write port and single registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/bfa_table.sv */
// ---------------------------------------------------------------------------
// bfa_table
// Block table memory holding start and length of each allocated run.
// ---------------------------------------------------------------------------
module bfa_table (
    input  logic                         i_clk,
    input  logic                         i_we,
    input  logic [bfa_pkg::SLOT_W-1:0]   i_waddr,
    input  bfa_pkg::t_entry              i_wdata,
    input  logic [bfa_pkg::SLOT_W-1:0]   i_raddr,
    output bfa_pkg::t_entry              o_rdata
);
    import bfa_pkg::*;

    t_entry r_mem [TABLE_ENTRIES];
    t_entry r_rdata;

    // Single write port and single registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/bfa_run_scan.sv */
// ---------------------------------------------------------------------------
// bfa_run_scan
// Search step: advances the free-run counter over one chunk of bits.
// ---------------------------------------------------------------------------
module bfa_run_scan (
    input  logic [bfa_pkg::CHUNK_W-1:0]                 i_bits,
    input  logic [bfa_pkg::PARA_W-bfa_pkg::CBIT_W-1:0]  i_base,
    input  logic [bfa_pkg::COUNT_W-1:0]                 i_count,
    input  bfa_pkg::t_scan                              i_scan,
    output bfa_pkg::t_scan                              o_scan
);
    import bfa_pkg::*;

    // Walk the chunk paragraph by paragraph, stopping at the first fit.
    always_comb begin
        t_scan s;
        s = i_scan;
        for (int j = 0; j < CHUNK_W; j++) begin
            if (!s.found) begin
                if (i_bits[j]) begin
                    s.run = '0;
                end else begin
                    if (s.run == '0) begin
                        s.start = {i_base, CBIT_W'(j)};
                    end
                    s.run = s.run + 1'b1;
                    if (s.run == i_count) begin
                        s.found = 1'b1;
                    end
                end
            end
        end
        o_scan = s;
    end

endmodule

/* rtl/bitmap_first_fit_page_allocator.sv */
// ---------------------------------------------------------------------------
// bitmap_first_fit_page_allocator
// First-fit allocator of 512-byte paragraphs with a block table.
// ---------------------------------------------------------------------------
// An allocate scans the bitmap 8 paragraphs a cycle, then the table one slot a
// cycle, then marks one word a cycle; a free scans the table one slot a cycle,
// then clears one word a cycle. A zero count on an allocate finishes without a
// search. One request at a time; the result waits in an output register.
// After reset a clearing pass over the table and bitmap runs first.
module bitmap_first_fit_page_allocator (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_mode,
    input  logic [bfa_pkg::COUNT_W-1:0]   i_count,
    input  logic [bfa_pkg::ADDR_W-1:0]    i_address,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [bfa_pkg::STATUS_W-1:0]  o_status,
    output logic [bfa_pkg::ADDR_W-1:0]    o_result_address
);
    import bfa_pkg::*;

    localparam logic [2:0] S_CLR   = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_ASCAN = 3'd2;
    localparam logic [2:0] S_SLOT  = 3'd3;
    localparam logic [2:0] S_FSCAN = 3'd4;
    localparam logic [2:0] S_MARK  = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [2:0]          r_state, n_state;
    logic [WADDR_W-1:0]  r_word, n_word;
    logic [CSEL_W-1:0]   r_chunk, n_chunk;
    logic [SLOT_W-1:0]   r_slot, n_slot;
    logic [COUNT_W-1:0]  r_run, n_run;
    logic [PARA_W-1:0]   r_start, n_start;
    logic [COUNT_W-1:0]  r_len, n_len;
    logic                r_set, n_set;
    logic [ADDR_W-1:0]   r_addr, n_addr;
    logic [STATUS_W-1:0] r_st, n_st;
    logic                r_ovalid;
    logic [STATUS_W-1:0] r_ostatus;
    logic [ADDR_W-1:0]   r_oaddr;

    logic                bm_we;
    logic [WADDR_W-1:0]  bm_waddr;
    logic [WORD_W-1:0]   bm_wdata, bm_rdata;
    logic                tb_we;
    logic [SLOT_W-1:0]   tb_waddr;
    t_entry              tb_wdata, tb_rdata;
    t_scan               scan_in, scan_out;
    logic [PARA_W-1:0]   end_para;
    logic [BIT_W-1:0]    lo_bit, hi_bit;
    logic [WORD_W-1:0]   mark_mask;
    logic                out_free;

    bfa_bitmap u_bitmap (
        .i_clk   (i_clk),
        .i_we    (bm_we),
        .i_waddr (bm_waddr),
        .i_wdata (bm_wdata),
        .i_raddr (n_word),
        .o_rdata (bm_rdata)
    );

    bfa_table u_table (
        .i_clk   (i_clk),
        .i_we    (tb_we),
        .i_waddr (tb_waddr),
        .i_wdata (tb_wdata),
        .i_raddr (n_slot),
        .o_rdata (tb_rdata)
    );

    // Search state for the current chunk of the bitmap word.
    assign scan_in = '{found: 1'b0, run: r_run, start: r_start};

    bfa_run_scan u_scan (
        .i_bits  (bm_rdata[r_chunk*CHUNK_W +: CHUNK_W]),
        .i_base  ({r_word, r_chunk}),
        .i_count (r_len),
        .i_scan  (scan_in),
        .o_scan  (scan_out)
    );

    // Bit range of the run that falls inside the current word.
    assign end_para  = PARA_W'(r_start + r_len - 1'b1);
    assign lo_bit    = (r_word == r_start[PARA_W-1:BIT_W]) ? r_start[BIT_W-1:0] : '0;
    assign hi_bit    = (r_word == end_para[PARA_W-1:BIT_W]) ? end_para[BIT_W-1:0] : '1;
    assign mark_mask = ({WORD_W{1'b1}} << lo_bit) & ({WORD_W{1'b1}} >> (~hi_bit));

    assign out_free   = !r_ovalid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE);

    // Sequencer.
    always_comb begin
        n_state  = r_state;
        n_word   = r_word;
        n_chunk  = r_chunk;
        n_slot   = r_slot;
        n_run    = r_run;
        n_start  = r_start;
        n_len    = r_len;
        n_set    = r_set;
        n_addr   = r_addr;
        n_st     = r_st;
        bm_we    = 1'b0;
        bm_waddr = r_word;
        bm_wdata = r_set ? (bm_rdata | mark_mask) : (bm_rdata & ~mark_mask);
        tb_we    = 1'b0;
        tb_waddr = r_slot;
        tb_wdata = '0;
        unique case (r_state)
            S_CLR: begin
                tb_we    = 1'b1;
                bm_we    = (r_slot < SLOT_W'(NUM_WORDS));
                bm_waddr = r_slot[WADDR_W-1:0];
                bm_wdata = (r_slot == '0) ? RESERVED_WORD : '0;
                n_slot   = r_slot + 1'b1;
                if (r_slot == SLOT_W'(TABLE_ENTRIES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_len   = i_count;
                    n_addr  = '0;
                    n_word  = '0;
                    n_chunk = '0;
                    n_slot  = '0;
                    n_run   = '0;
                    if (i_mode) begin
                        n_addr  = i_address;
                        n_state = S_FSCAN;
                    end else if (i_count == '0) begin
                        n_st    = ST_ZERO;
                        n_state = S_DONE;
                    end else begin
                        n_state = S_ASCAN;
                    end
                end
            end
            S_ASCAN: begin
                n_run   = scan_out.run;
                n_start = scan_out.start;
                n_chunk = r_chunk + 1'b1;
                if (scan_out.found) begin
                    n_slot  = '0;
                    n_state = S_SLOT;
                end else if (r_chunk == '1) begin
                    if (r_word == '1) begin
                        n_st    = ST_NO_RUN;
                        n_state = S_DONE;
                    end else begin
                        n_word = r_word + 1'b1;
                    end
                end
            end
            S_SLOT: begin
                if (tb_rdata.len == '0) begin
                    tb_we    = 1'b1;
                    tb_wdata = '{start: r_start, len: r_len};
                    n_set    = 1'b1;
                    n_addr   = para_addr(r_start);
                    n_word   = r_start[PARA_W-1:BIT_W];
                    n_state  = S_MARK;
                end else if (r_slot == '1) begin
                    n_st    = ST_FULL;
                    n_state = S_DONE;
                end else begin
                    n_slot = r_slot + 1'b1;
                end
            end
            S_FSCAN: begin
                if (tb_rdata.len != '0 && para_addr(tb_rdata.start) == r_addr) begin
                    tb_we   = 1'b1;
                    n_start = tb_rdata.start;
                    n_len   = tb_rdata.len;
                    n_set   = 1'b0;
                    n_word  = tb_rdata.start[PARA_W-1:BIT_W];
                    n_state = S_MARK;
                end else if (r_slot == '1) begin
                    n_addr  = '0;
                    n_st    = ST_NOT_FOUND;
                    n_state = S_DONE;
                end else begin
                    n_slot = r_slot + 1'b1;
                end
            end
            S_MARK: begin
                bm_we = 1'b1;
                if (r_word == end_para[PARA_W-1:BIT_W]) begin
                    n_st    = ST_OK;
                    n_state = S_DONE;
                end else begin
                    n_word = r_word + 1'b1;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_slot   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_slot  <= n_slot;
            if (r_state == S_DONE && out_free) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Working and result registers.
    always_ff @(posedge i_clk) begin
        r_word  <= n_word;
        r_chunk <= n_chunk;
        r_run   <= n_run;
        r_start <= n_start;
        r_len   <= n_len;
        r_set   <= n_set;
        r_addr  <= n_addr;
        r_st    <= n_st;
        if (r_state == S_DONE && out_free) begin
            r_ostatus <= r_st;
            r_oaddr   <= (r_st == ST_OK) ? r_addr : '0;
        end
    end

    assign o_out_valid      = r_ovalid;
    assign o_status         = r_ostatus;
    assign o_result_address = r_oaddr;

endmodule
